/* hdl/quaternion_exponential_step_top_assert.svh */
// Assertion macros shared by the square root and divider pipelines.
`ifndef QUATERNION_EXPONENTIAL_STEP_TOP_ASSERT_SVH
`define QUATERNION_EXPONENTIAL_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QES_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define QES_ASSERT(name, prop) `QES_ASSERT_CLK(name, clk_i, rst_ni, prop)
`else
`define QES_ASSERT_CLK(name, clk, rst_n, prop)
`define QES_ASSERT(name, prop)
`endif
`endif

/* hdl/qes_pkg.sv */
`timescale 1ns / 1ps
package qes_pkg;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [35:0] s36_t;
  typedef logic signed [39:0] s40_t;
  typedef logic signed [63:0] s64_t;
  typedef logic signed [71:0] s72_t;

  // Output saturation width.
  localparam int unsigned CompWidth = 32;
  localparam int unsigned Frac = 30;

  // Step and stage counts of the pipelined units.
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned SqrtStages = 16;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned DivStages = 16;
  localparam int unsigned TrigStages = 16;

  localparam longint OneInt = 1073741824;
  localparam s32_t OneQ = 32'sd1073741824;

  // Series coefficients 2^30/n, rounded.
  localparam s32_t SinRc0 = 32'((OneInt + 3) / 6);
  localparam s32_t SinRc1 = 32'((OneInt + 10) / 20);
  localparam s32_t SinRc2 = 32'((OneInt + 21) / 42);
  localparam s32_t SinRc3 = 32'((OneInt + 36) / 72);
  localparam s32_t SinRc4 = 32'((OneInt + 55) / 110);
  localparam s32_t CosRc0 = 32'((OneInt + 1) / 2);
  localparam s32_t CosRc1 = 32'((OneInt + 6) / 12);
  localparam s32_t CosRc2 = 32'((OneInt + 15) / 30);
  localparam s32_t CosRc3 = 32'((OneInt + 28) / 56);
  localparam s32_t CosRc4 = 32'((OneInt + 45) / 90);
  localparam s32_t CosRc5 = 32'((OneInt + 66) / 132);

  // Quarter turn in Q.32 and the series threshold on the squared length.
  localparam longint HalfPi = 64'd6746518852;
  localparam longint HalfPiHalf = HalfPi / 2;
  localparam logic [63:0] SeriesLimit = 64'd485668183815635;

  localparam s72_t SatHi = s72_t'((72'd1 << (CompWidth - 1)) - 72'd1);
  localparam s72_t SatLo = -SatHi - 72'sd1;

  // One request as it travels down the pipeline.
  typedef struct packed {
    s32_t [3:0]        q;
    s32_t [2:0]        d;
    logic [2:0][63:0]  dsq;
    logic [63:0]       sum;
    logic              zero;
    logic              series;
    logic [4:0]        k;
    logic [63:0]       sq_v;
    logic [63:0]       sq_res;
    logic [34:0]       h32;
    logic [2:0][31:0]  dv_rem;
    logic [2:0][30:0]  dv_low;
    s64_t [11:0]       prod;
    s36_t [3:0]        nv;
    logic [2:0]        j;
    s36_t              res;
    s32_t              a;
    s32_t              a2;
    s32_t              x;
    s32_t              hs;
    s32_t              ec_t;
    s32_t              ec_acc;
    s32_t              es_t;
    s32_t              es_acc;
    s32_t              sc_t;
    s32_t              sc_acc;
    s32_t              ss_t;
    s32_t              ss_acc;
    s32_t              sr;
    s32_t              omc;
    s32_t              sser;
    s32_t              base;
    s32_t              cc;
    s32_t              sv;
    s40_t [3:0]        tc;
    s40_t [3:0]        ts;
  } item_t;

  // Divide by 2^sh, rounding to nearest with ties away from zero.
  function automatic s72_t rnd_shr(input s72_t v, input int unsigned sh);
    logic [71:0] mag;
    logic        neg;
    neg = v[71];
    mag = neg ? 72'(-v) : 72'(v);
    mag = (mag + (72'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Product of two Q2.30 values, rounded back to Q2.30.
  function automatic s32_t mulq(input s32_t a, input s32_t b);
    s64_t p;
    p = s64_t'(a) * s64_t'(b);
    return s32_t'(rnd_shr(s72_t'(p), Frac));
  endfunction

  function automatic s32_t sin_coef(input logic [2:0] i);
    s32_t c;
    unique case (i)
      3'd0: c = SinRc0;
      3'd1: c = SinRc1;
      3'd2: c = SinRc2;
      3'd3: c = SinRc3;
      default: c = SinRc4;
    endcase
    return c;
  endfunction

  function automatic s32_t cos_coef(input logic [2:0] i);
    s32_t c;
    unique case (i)
      3'd0: c = CosRc0;
      3'd1: c = CosRc1;
      3'd2: c = CosRc2;
      3'd3: c = CosRc3;
      3'd4: c = CosRc4;
      default: c = CosRc5;
    endcase
    return c;
  endfunction

  // Nearest multiple of a quarter turn to the half angle.
  function automatic logic [2:0] quarter_of(input logic [34:0] h);
    logic [2:0] j;
    j = 3'd0;
    for (int i = 1; i <= 5; i++) begin
      if ({1'b0, h} >= 36'(i * HalfPi - HalfPiHalf)) j = 3'(i);
    end
    return j;
  endfunction

  function automatic logic [31:0] saturate(input s72_t v);
    s72_t t;
    t = v;
    if (t > SatHi) t = SatHi;
    if (t < SatLo) t = SatLo;
    return t[31:0];
  endfunction

endpackage

/* hdl/quaternion_exponential_step_top.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle; busy_o never rises, every stage is registered.
// The depth is set by the 16-stage square root, 16-stage divider and 16-stage
// sine/cosine series chain. Reset clears all valid bits; data registers keep no reset.
// Results cannot be held off by the receiver.
module quaternion_exponential_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] quat_in_w_i,
  input  logic [31:0] quat_in_x_i,
  input  logic [31:0] quat_in_y_i,
  input  logic [31:0] quat_in_z_i,
  input  logic [31:0] angle_step_x_i,
  input  logic [31:0] angle_step_y_i,
  input  logic [31:0] angle_step_z_i,
  output logic        done_o,
  output logic [31:0] quat_out_w_o,
  output logic [31:0] quat_out_x_o,
  output logic [31:0] quat_out_y_o,
  output logic [31:0] quat_out_z_o
);
  import qes_pkg::*;

  logic  v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic  vs_o, vd_o, vt_o;
  item_t p0_d, p1_d, p2_d, p3_d, p4_d, p5_d, p6_d, p7_d;
  item_t p0_q, p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q;
  item_t ps_o, pd_o, pt_o;
  logic  done_q;
  logic [3:0][31:0] out_d, out_q;

  assign busy_o = 1'b0;

  // Capture the request.
  always_comb begin
    p0_d      = '0;
    p0_d.q[0] = quat_in_w_i;
    p0_d.q[1] = quat_in_x_i;
    p0_d.q[2] = quat_in_y_i;
    p0_d.q[3] = quat_in_z_i;
    p0_d.d[0] = angle_step_x_i;
    p0_d.d[1] = angle_step_y_i;
    p0_d.d[2] = angle_step_z_i;
  end

  // Squares of the increment.
  always_comb begin
    s64_t sq;
    p1_d = p0_q;
    for (int c = 0; c < 3; c++) begin
      sq = s64_t'(p0_q.d[c]) * s64_t'(p0_q.d[c]);
      p1_d.dsq[c] = sq;
    end
  end

  // Squared length and branch flags.
  always_comb begin
    p2_d        = p1_q;
    p2_d.sum    = p1_q.dsq[0] + p1_q.dsq[1] + p1_q.dsq[2];
    p2_d.zero   = p2_d.sum == 64'd0;
    p2_d.series = p2_d.sum < SeriesLimit;
  end

  // Normalize by an even shift so the top bit pair is set.
  always_comb begin
    int top;
    p3_d = p2_q;
    top  = 31;
    for (int i = 0; i < 32; i++) begin
      if (p2_q.sum[2*i +: 2] != 2'd0) top = i;
    end
    p3_d.k      = 5'(31 - top);
    p3_d.sq_v   = p2_q.sum << (2 * p3_d.k);
    p3_d.sq_res = '0;
  end

  qes_isqrt_pipe u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .item_i  (p3_q),
    .valid_o (vs_o),
    .item_o  (ps_o)
  );

  // Half angle and divider operands.
  always_comb begin
    logic [31:0] root;
    logic [31:0] mag;
    logic [92:0] num;
    p4_d = ps_o;
    root = ps_o.sq_res[31:0];
    if (ps_o.k >= 5'd3) begin
      p4_d.h32 = 35'(root >> (ps_o.k - 5'd3));
    end else begin
      p4_d.h32 = 35'({3'd0, root} << (5'd3 - ps_o.k));
    end
    for (int c = 0; c < 3; c++) begin
      mag = ps_o.d[c][31] ? (~ps_o.d[c] + 32'd1) : ps_o.d[c];
      num = ({61'd0, mag} << (7'(ps_o.k) + 7'd30)) + {62'd0, root[31:1]};
      p4_d.dv_rem[c] = num[62:31];
      p4_d.dv_low[c] = num[30:0];
    end
  end

  qes_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .item_i  (p4_q),
    .valid_o (vd_o),
    .item_o  (pd_o)
  );

  // Negated unit axis times the quaternion, term by term.
  always_comb begin
    s32_t [2:0] m;
    s32_t       quo;
    p5_d = pd_o;
    for (int c = 0; c < 3; c++) begin
      quo  = s32_t'({1'b0, pd_o.dv_low[c]});
      m[c] = pd_o.d[c][31] ? quo : -quo;
    end
    p5_d.prod[0]  = s64_t'(m[0]) * s64_t'(pd_o.q[1]);
    p5_d.prod[1]  = s64_t'(m[1]) * s64_t'(pd_o.q[2]);
    p5_d.prod[2]  = s64_t'(m[2]) * s64_t'(pd_o.q[3]);
    p5_d.prod[3]  = s64_t'(m[0]) * s64_t'(pd_o.q[0]);
    p5_d.prod[4]  = s64_t'(m[1]) * s64_t'(pd_o.q[3]);
    p5_d.prod[5]  = s64_t'(m[2]) * s64_t'(pd_o.q[2]);
    p5_d.prod[6]  = s64_t'(m[1]) * s64_t'(pd_o.q[0]);
    p5_d.prod[7]  = s64_t'(m[2]) * s64_t'(pd_o.q[1]);
    p5_d.prod[8]  = s64_t'(m[0]) * s64_t'(pd_o.q[3]);
    p5_d.prod[9]  = s64_t'(m[2]) * s64_t'(pd_o.q[0]);
    p5_d.prod[10] = s64_t'(m[0]) * s64_t'(pd_o.q[2]);
    p5_d.prod[11] = s64_t'(m[1]) * s64_t'(pd_o.q[1]);
  end

  // Sum the terms of the rotated axis quaternion and round to Q6.30.
  always_comb begin
    s72_t [11:0] pe;
    p6_d = p5_q;
    for (int i = 0; i < 12; i++) begin
      pe[i] = s72_t'(p5_q.prod[i]);
    end
    p6_d.nv[0] = s36_t'(rnd_shr(-(pe[0] + pe[1] + pe[2]), Frac));
    p6_d.nv[1] = s36_t'(rnd_shr(pe[3] + pe[4] - pe[5], Frac));
    p6_d.nv[2] = s36_t'(rnd_shr(pe[6] + pe[7] - pe[8], Frac));
    p6_d.nv[3] = s36_t'(rnd_shr(pe[9] + pe[10] - pe[11], Frac));
  end

  qes_trig_pipe u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .item_i  (p6_q),
    .valid_o (vt_o),
    .item_o  (pt_o)
  );

  // Scaled terms of the update.
  always_comb begin
    p7_d = pt_o;
    for (int i = 0; i < 4; i++) begin
      p7_d.tc[i] = s40_t'(rnd_shr(s72_t'(s64_t'(pt_o.cc) * s64_t'(pt_o.q[i])), Frac));
      p7_d.ts[i] = s40_t'(rnd_shr(s72_t'(pt_o.sv) * s72_t'(pt_o.nv[i]), Frac));
    end
  end

  // Final sum and saturation; the base term is the input quaternion when used.
  always_comb begin
    s72_t acc;
    for (int i = 0; i < 4; i++) begin
      acc = s72_t'(p7_q.tc[i]) + s72_t'(p7_q.ts[i]);
      if (p7_q.base != '0 || p7_q.zero || p7_q.series) begin
        acc = acc + ((p7_q.zero || p7_q.series) ? s72_t'(p7_q.q[i]) : 72'sd0);
      end
      out_d[i] = saturate(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start_i && !busy_o;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= vs_o;
      v5_q   <= vd_o;
      v6_q   <= v5_q;
      v7_q   <= vt_o;
      done_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q  <= p0_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    p3_q  <= p3_d;
    p4_q  <= p4_d;
    p5_q  <= p5_d;
    p6_q  <= p6_d;
    p7_q  <= p7_d;
    out_q <= out_d;
  end

  assign done_o       = done_q;
  assign quat_out_w_o = out_q[0];
  assign quat_out_x_o = out_q[1];
  assign quat_out_y_o = out_q[2];
  assign quat_out_z_o = out_q[3];
endmodule

/* hdl/qes_isqrt_pipe.sv */
`timescale 1ns / 1ps
`include "quaternion_exponential_step_top_assert.svh"
module qes_isqrt_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  qes_pkg::item_t  item_i,
  output logic            valid_o,
  output qes_pkg::item_t  item_o
);
  import qes_pkg::*;

  logic [SqrtStages-1:0] v_q;
  logic [SqrtStages-1:0] v_in;
  item_t                 it_in [SqrtStages];
  item_t                 it_d  [SqrtStages];
  item_t                 it_q  [SqrtStages];

  for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign v_in[g]  = valid_i;
      assign it_in[g] = item_i;
    end else begin : g_next
      assign v_in[g]  = v_q[g-1];
      assign it_in[g] = it_q[g-1];
    end

    // Two digits of the bitwise square root per stage.
    always_comb begin
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] sbit;
      it_d[g] = it_in[g];
      rem  = it_in[g].sq_v;
      root = it_in[g].sq_res;
      for (int b = 0; b < 2; b++) begin
        sbit = 64'd1 << (62 - 2 * (2 * g + b));
        if (rem >= root + sbit) begin
          rem  = rem - (root + sbit);
          root = (root >> 1) + sbit;
        end else begin
          root = root >> 1;
        end
      end
      it_d[g].sq_v   = rem;
      it_d[g].sq_res = root;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[g] <= it_d[g];
    end
  end

  assign valid_o = v_q[SqrtStages-1];
  assign item_o  = it_q[SqrtStages-1];

  // Root bounds, recomputed from the stored sum and shift.
  logic [63:0] ns_chk;
  logic [32:0] root_p1;
  logic [65:0] root_sq;
  logic [65:0] root_p1_sq;
  assign ns_chk     = item_o.sum << (2 * item_o.k);
  assign root_p1    = {1'b0, item_o.sq_res[31:0]} + 33'd1;
  assign root_sq    = 66'(item_o.sq_res[31:0]) * 66'(item_o.sq_res[31:0]);
  assign root_p1_sq = 66'(root_p1) * 66'(root_p1);

  `QES_ASSERT(a_norm_top, valid_o && !item_o.zero |-> ns_chk[63:62] != 2'd0)
  `QES_ASSERT(a_root_low, valid_o && !item_o.zero |-> root_sq <= {2'd0, ns_chk})
  `QES_ASSERT(a_root_high, valid_o && !item_o.zero |-> root_p1_sq > {2'd0, ns_chk})
endmodule

/* hdl/qes_div_pipe.sv */
`timescale 1ns / 1ps
`include "quaternion_exponential_step_top_assert.svh"
module qes_div_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  qes_pkg::item_t  item_i,
  output logic            valid_o,
  output qes_pkg::item_t  item_o
);
  import qes_pkg::*;

  logic [DivStages-1:0] v_q;
  logic [DivStages-1:0] v_in;
  item_t                it_in [DivStages];
  item_t                it_d  [DivStages];
  item_t                it_q  [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign v_in[g]  = valid_i;
      assign it_in[g] = item_i;
    end else begin : g_next
      assign v_in[g]  = v_q[g-1];
      assign it_in[g] = it_q[g-1];
    end

    // Two restoring steps per stage for each axis, one in the last stage; quotient bits shift into low.
    always_comb begin
      logic [32:0] trial;
      logic [31:0] rem;
      logic [30:0] low;
      logic        qb;
      it_d[g] = it_in[g];
      for (int c = 0; c < 3; c++) begin
        rem = it_in[g].dv_rem[c];
        low = it_in[g].dv_low[c];
        for (int b = 0; b < 2; b++) begin
          if (2 * g + b < DivSteps) begin
            trial = {rem, low[30]};
            qb    = trial >= {1'b0, it_in[g].sq_res[31:0]};
            if (qb) begin
              trial = trial - {1'b0, it_in[g].sq_res[31:0]};
            end
            rem = trial[31:0];
            low = {low[29:0], qb};
          end
        end
        it_d[g].dv_rem[c] = rem;
        it_d[g].dv_low[c] = low;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[g] <= it_d[g];
    end
  end

  assign valid_o = v_q[DivStages-1];
  assign item_o  = it_q[DivStages-1];

  // Remainders stay below the divisor and quotients stay no more than one LSB above one.
  logic rem_ok;
  logic quo_ok;
  assign rem_ok = item_o.dv_rem[0] < item_o.sq_res[31:0] &&
                  item_o.dv_rem[1] < item_o.sq_res[31:0] &&
                  item_o.dv_rem[2] < item_o.sq_res[31:0];
  assign quo_ok = item_o.dv_low[0] <= 31'd1073741825 &&
                  item_o.dv_low[1] <= 31'd1073741825 &&
                  item_o.dv_low[2] <= 31'd1073741825;

  `QES_ASSERT(a_root_norm, valid_o && !item_o.zero |-> item_o.sq_res[31])
  `QES_ASSERT(a_rem_below, valid_o && !item_o.zero |-> rem_ok)
  `QES_ASSERT(a_quo_range, valid_o && !item_o.zero |-> quo_ok)
endmodule

/* hdl/qes_trig_pipe.sv */
`timescale 1ns / 1ps
module qes_trig_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  qes_pkg::item_t  item_i,
  output logic            valid_o,
  output qes_pkg::item_t  item_o
);
  import qes_pkg::*;

  logic [TrigStages-1:0] v_q;
  logic [TrigStages-1:0] v_in;
  item_t                 it_in [TrigStages];
  item_t                 it_d  [TrigStages];
  item_t                 it_q  [TrigStages];

  for (genvar g = 0; g < TrigStages; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign v_in[g]  = valid_i;
      assign it_in[g] = item_i;
      // Range reduction by the nearest quarter turn, and series inputs.
      always_comb begin
        logic [2:0] jq;
        it_d[g]        = it_in[g];
        jq             = quarter_of(it_in[g].h32);
        it_d[g].j      = jq;
        it_d[g].res    = s36_t'(s72_t'({1'b0, it_in[g].h32}) - s72_t'(longint'(jq) * HalfPi));
        it_d[g].x      = s32_t'((it_in[g].sum + 64'd134217728) >> 28);
        it_d[g].hs     = s32_t'(it_in[g].h32[31:0]);
        it_d[g].ec_acc = OneQ;
        it_d[g].es_acc = OneQ;
        it_d[g].sc_acc = OneQ;
        it_d[g].ss_acc = OneQ;
      end
    end else if (g == 1) begin : g_resid
      assign v_in[g]  = v_q[g-1];
      assign it_in[g] = it_q[g-1];
      always_comb begin
        it_d[g]   = it_in[g];
        it_d[g].a = s32_t'(rnd_shr(s72_t'(it_in[g].res), 2));
      end
    end else if (g == 2) begin : g_square
      assign v_in[g]  = v_q[g-1];
      assign it_in[g] = it_q[g-1];
      always_comb begin
        it_d[g]    = it_in[g];
        it_d[g].a2 = mulq(it_in[g].a, it_in[g].a);
      end
    end else begin : g_chain
      localparam int Lv = (g - 3) / 2;
      localparam int Ph = (g - 3) % 2;
      assign v_in[g]  = v_q[g-1];
      assign it_in[g] = it_q[g-1];
      // Nested series: one multiply by the coefficient, then one by the accumulator.
      always_comb begin
        s32_t cs;
        s32_t cr;
        it_d[g] = it_in[g];
        if (Lv < 6) begin
          if (Ph == 0) begin
            it_d[g].ec_t = mulq(it_in[g].a2, cos_coef(3'(5 - Lv)));
          end else begin
            it_d[g].ec_acc = OneQ - mulq(it_in[g].ec_t, it_in[g].ec_acc);
          end
        end
        if (Lv < 5) begin
          if (Ph == 0) begin
            it_d[g].es_t = mulq(it_in[g].a2, sin_coef(3'(4 - Lv)));
          end else begin
            it_d[g].es_acc = OneQ - mulq(it_in[g].es_t, it_in[g].es_acc);
          end
        end
        if (Lv < 2) begin
          if (Ph == 0) begin
            it_d[g].sc_t = mulq(it_in[g].x, cos_coef(3'(2 - Lv)));
          end else begin
            it_d[g].sc_acc = OneQ - mulq(it_in[g].sc_t, it_in[g].sc_acc);
          end
        end
        if (Lv < 3) begin
          if (Ph == 0) begin
            it_d[g].ss_t = mulq(it_in[g].x, sin_coef(3'(2 - Lv)));
          end else begin
            it_d[g].ss_acc = OneQ - mulq(it_in[g].ss_t, it_in[g].ss_acc);
          end
        end
        // Series results once their short chains are done.
        if (g == 9) begin
          it_d[g].omc  = s32_t'(rnd_shr(
              s72_t'(s64_t'(it_in[g].x) * s64_t'(it_in[g].sc_acc)), 31));
          it_d[g].sser = s32_t'(rnd_shr(
              s72_t'(s64_t'(it_in[g].hs) * s64_t'(it_in[g].ss_acc)), 32));
        end
        if (g == 13) begin
          it_d[g].sr = mulq(it_in[g].a, it_in[g].es_acc);
        end
        // Quadrant mapping and choice of the update form.
        cs = it_in[g].sr;
        cr = it_in[g].ec_acc;
        if (g == TrigStages - 1) begin
          unique case (it_in[g].j[1:0])
            2'd0: begin
              cs = it_in[g].sr;
              cr = it_in[g].ec_acc;
            end
            2'd1: begin
              cs = it_in[g].ec_acc;
              cr = -it_in[g].sr;
            end
            2'd2: begin
              cs = -it_in[g].sr;
              cr = -it_in[g].ec_acc;
            end
            2'd3: begin
              cs = -it_in[g].ec_acc;
              cr = it_in[g].sr;
            end
          endcase
          priority if (it_in[g].zero) begin
            it_d[g].base = it_in[g].q[0];
            it_d[g].cc   = '0;
            it_d[g].sv   = '0;
          end else if (it_in[g].series) begin
            it_d[g].base = it_in[g].q[0];
            it_d[g].cc   = -it_in[g].omc;
            it_d[g].sv   = it_in[g].sser;
          end else begin
            it_d[g].base = '0;
            it_d[g].cc   = cr;
            it_d[g].sv   = cs;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      it_q[g] <= it_d[g];
    end
  end

  assign valid_o = v_q[TrigStages-1];
  assign item_o  = it_q[TrigStages-1];
endmodule
